### rtl/xpba_pkg.sv
// shared types and constants for the xor pir block accumulator
// no dependencies; used by every rtl file of the block
`default_nettype none

package xpba_pkg;

    localparam int BLOCK_WORDS_DEFAULT = 256;

    localparam int WORD_W  = 64;
    localparam int IDX_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int LANES   = WORD_W / BYTE_W;
    localparam int TDATA_W = WORD_W + IDX_W;
    localparam int TUSER_W = 2;

    // tuser bit positions on the input channel
    localparam int TUSER_SELECT = 0;
    localparam int TUSER_FIRST  = 1;

    // result queue
    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 2;

    // per-cycle control for the write stage of every byte lane
    typedef struct packed {
        logic wr_en;
        logic load;
        logic select;
        logic bypass;
        logic corrupt;
    } xpba_lane_ctrl_t;

endpackage

`default_nettype wire

### rtl/xpba_lane.sv
// one byte lane: byte-wide accumulator bank, read-modify-write with bypass
// depends on xpba_pkg
`default_nettype none

module xpba_lane #(
    parameter int BLOCK_WORDS = xpba_pkg::BLOCK_WORDS_DEFAULT,
    localparam int ADDR_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    input  wire logic [xpba_pkg::BYTE_W-1:0] in_byte,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire xpba_pkg::xpba_lane_ctrl_t   ctrl,
    output logic      [xpba_pkg::BYTE_W-1:0] out_byte
);

    logic [xpba_pkg::BYTE_W-1:0] bank [BLOCK_WORDS];
    logic [xpba_pkg::BYTE_W-1:0] byte_reg;
    logic [xpba_pkg::BYTE_W-1:0] rd_data_reg;
    logic [xpba_pkg::BYTE_W-1:0] byp_data_reg;
    logic [xpba_pkg::BYTE_W-1:0] contrib;
    logic [xpba_pkg::BYTE_W-1:0] old_entry;
    logic [xpba_pkg::BYTE_W-1:0] entry_next;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byte_reg    <= in_byte;
            rd_data_reg <= bank[rd_addr];
        end
    end

    always_comb begin
        contrib    = ctrl.select ? byte_reg : '0;
        old_entry  = ctrl.bypass ? byp_data_reg : rd_data_reg;
        entry_next = ctrl.load ? contrib : (old_entry ^ contrib);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            bank[wr_addr] <= entry_next;
            byp_data_reg  <= entry_next;
        end
    end

    // corrupt mode bumps the emitted byte only, wrapping
    assign out_byte = ctrl.corrupt ? (entry_next + xpba_pkg::BYTE_W'(1)) : entry_next;

endmodule

`default_nettype wire

### rtl/xpba_merge.sv
// merging stage: gathers lane bytes into result words and queues them for the master side
// depends on xpba_pkg
`default_nettype none

module xpba_merge (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              push,
    input  wire logic [xpba_pkg::TDATA_W-1:0]      push_data,
    output logic      [xpba_pkg::QUEUE_CNT_W-1:0]  level,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [xpba_pkg::TDATA_W-1:0]      m_tdata
);

    logic [xpba_pkg::TDATA_W-1:0]     slot_reg [xpba_pkg::QUEUE_DEPTH];
    logic [xpba_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [xpba_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [xpba_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                             pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = slot_reg[rd_ptr_reg];
    assign level    = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == xpba_pkg::QUEUE_PTR_W'(xpba_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + xpba_pkg::QUEUE_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == xpba_pkg::QUEUE_PTR_W'(xpba_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + xpba_pkg::QUEUE_PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + xpba_pkg::QUEUE_CNT_W'(1);
        end else if (!push && pop) begin
            cnt_next = cnt_reg - xpba_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/xor_pir_block_accumulator_unit.sv
// top level of the xor pir block accumulator: input stage, byte lanes, merging stage
// depends on xpba_pkg, xpba_lane and xpba_merge
`default_nettype none

// Server-side accumulator for XOR-based PIR. Each input transfer carries one
// database word with its position in the block and the query bits; the word is
// XORed into the accumulator entry at that position when selected, loaded in
// place of the old entry on the first block, and the finished entry is sent out
// as a result on the last block. The word is split over eight byte lanes, each
// with its own byte-wide bank of BLOCK_WORDS entries; the merging stage puts the
// lane bytes back together and queues results. One item is taken every clock
// cycle while the three-deep result queue has room: each lane does one
// read-modify-write of its bank per item, the read in the accept cycle and the
// write in the next, with a bypass register covering an item that hits the entry
// the previous item has just written. s_tready drops while the queued results plus
// a result in the write stage fill all three slots, so a stalled master side holds
// the input off. A result is formed in the write stage and registered in the result
// queue before it shows on m_tvalid. The banks need no clearing after reset, since
// the first block of a query overwrites every entry it uses. Words with word_index
// at or beyond BLOCK_WORDS are dropped. corrupt_mode adds one to every result byte
// (wrapping) and must only be written while idle.

module xor_pir_block_accumulator_unit #(
    parameter int BLOCK_WORDS = xpba_pkg::BLOCK_WORDS_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [xpba_pkg::TDATA_W-1:0]       s_tdata,  // data_word, word_index
    input  wire logic [xpba_pkg::TUSER_W-1:0]       s_tuser,  // select, first_block
    input  wire logic                               s_tlast,  // last_block

    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [xpba_pkg::TDATA_W-1:0]       m_tdata,  // result_word, result_index

    // configuration: corrupt_mode
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_data
);

    localparam int ADDR_W = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int EXT_W  = xpba_pkg::IDX_W + ADDR_W;

    logic                             corrupt_reg;

    logic                             accept;
    logic [EXT_W-1:0]                 idx_ext;
    logic                             in_range;
    logic [ADDR_W-1:0]                rd_addr;

    // write stage of an item, following its bank read
    logic                             p1_valid_reg;
    logic [ADDR_W-1:0]                p1_addr_reg;
    logic [xpba_pkg::IDX_W-1:0]       p1_index_reg;
    logic                             p1_first_reg;
    logic                             p1_sel_reg;
    logic                             p1_last_reg;

    // last write, for back-to-back hits on the same entry
    logic                             byp_valid_reg;
    logic [ADDR_W-1:0]                byp_addr_reg;

    xpba_pkg::xpba_lane_ctrl_t        lane_ctrl;
    logic [xpba_pkg::WORD_W-1:0]      result_word;
    logic                             push;
    logic [xpba_pkg::QUEUE_CNT_W-1:0] level;
    logic [xpba_pkg::QUEUE_CNT_W:0]   pending;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corrupt_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            corrupt_reg <= cfg_data;
        end
    end

    // space check: queued results plus one possibly in flight must leave a free slot
    assign pending  = {1'b0, level} + (xpba_pkg::QUEUE_CNT_W + 1)'(p1_valid_reg && p1_last_reg);
    assign s_tready = (pending < (xpba_pkg::QUEUE_CNT_W + 1)'(xpba_pkg::QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // word_index widened so that any block depth compares and addresses cleanly
    assign idx_ext  = {{ADDR_W{1'b0}}, s_tdata[xpba_pkg::WORD_W +: xpba_pkg::IDX_W]};
    assign in_range = (idx_ext < EXT_W'(BLOCK_WORDS));
    assign rd_addr  = idx_ext[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= accept && in_range;
            byp_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_addr_reg  <= rd_addr;
            p1_index_reg <= s_tdata[xpba_pkg::WORD_W +: xpba_pkg::IDX_W];
            p1_first_reg <= s_tuser[xpba_pkg::TUSER_FIRST];
            p1_sel_reg   <= s_tuser[xpba_pkg::TUSER_SELECT];
            p1_last_reg  <= s_tlast;
        end
        if (p1_valid_reg) begin
            byp_addr_reg <= p1_addr_reg;
        end
    end

    always_comb begin
        lane_ctrl.wr_en   = p1_valid_reg;
        lane_ctrl.load    = p1_first_reg;
        lane_ctrl.select  = p1_sel_reg;
        // bank read missed the write made at the same edge
        lane_ctrl.bypass  = byp_valid_reg && (byp_addr_reg == p1_addr_reg);
        lane_ctrl.corrupt = corrupt_reg;
    end

    for (genvar l = 0; l < xpba_pkg::LANES; l++) begin : g_lane
        xpba_lane #(
            .BLOCK_WORDS (BLOCK_WORDS)
        ) u_lane (
            .aclk     (aclk),
            .rd_en    (accept && in_range),
            .rd_addr  (rd_addr),
            .in_byte  (s_tdata[l*xpba_pkg::BYTE_W +: xpba_pkg::BYTE_W]),
            .wr_addr  (p1_addr_reg),
            .ctrl     (lane_ctrl),
            .out_byte (result_word[l*xpba_pkg::BYTE_W +: xpba_pkg::BYTE_W])
        );
    end

    // only the last block of a query produces a result
    assign push = p1_valid_reg && p1_last_reg;

    xpba_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({p1_index_reg, result_word}),
        .level     (level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
